/* sv/sdr_pkg.sv */
package sdr_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned Steps = DataW;
	localparam int unsigned InTdataW = 2 * DataW;
	localparam int unsigned OutTdataW = 3 * DataW;

	typedef struct packed {
		logic [DataW-1:0] rem;   // partial remainder
		logic [DataW-1:0] quo;   // dividend bits out the top, quotient bits in the bottom
		logic [DataW-1:0] den;   // divisor magnitude
		logic [DataW-1:0] num;   // raw numerator, for divide by zero
		logic             n_neg;
		logic             q_neg;
		logic             dbz;
	} sdr_work_t;

endpackage

/* sv/signed_divide_remainder_unit.sv */
// Pipelined 32-bit signed divider with remainder.
// Input stream: s_tdata carries numerator and denominator; a word is taken
// when s_tvalid and s_tready are both high.
// Output stream: m_tdata carries quotient (truncated toward zero), remainder
// (sign of the numerator) and the quotient magnitude; m_tuser flags a zero
// denominator, in which case quotient and magnitude are 0 and the remainder
// is the numerator.
// Pipeline: one operand stage, 32 restoring subtract stages (one quotient
// bit per stage), then one sign-fix and output register stage.
// Throughput: one word per cycle while the output is not stalled.
// When m_tready is low while m_tvalid is high the whole pipeline holds and
// s_tready drops; no word is lost or repeated.
// Reset clears all valid bits; the pipeline comes up empty.
module signed_divide_remainder_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sdr_pkg::InTdataW-1:0]     s_tdata,  // numerator, denominator
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sdr_pkg::OutTdataW-1:0]    m_tdata,  // quotient, remainder, quotient_magnitude
	output logic                             m_tuser   // divide_by_zero
);

	logic                      en;
	logic                      valid_c [sdr_pkg::Steps+1];
	sdr_pkg::sdr_work_t        work_c  [sdr_pkg::Steps+1];
	logic [sdr_pkg::DataW-1:0] quotient;
	logic [sdr_pkg::DataW-1:0] remainder;
	logic [sdr_pkg::DataW-1:0] quotient_magnitude;

	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	sdr_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_tvalid),
		.numerator   (s_tdata[sdr_pkg::DataW-1:0]),
		.denominator (s_tdata[2*sdr_pkg::DataW-1:sdr_pkg::DataW]),
		.valid_s1    (valid_c[0]),
		.work_s1     (work_c[0])
	);

	for (genvar i = 0; i < sdr_pkg::Steps; i++) begin : g_step
		sdr_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (valid_c[i]),
			.in_work  (work_c[i]),
			.valid_q  (valid_c[i+1]),
			.work_q   (work_c[i+1])
		);
	end

	sdr_fix u_fix (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (valid_c[sdr_pkg::Steps]),
		.in_work     (work_c[sdr_pkg::Steps]),
		.valid_q     (m_tvalid),
		.quotient_q  (quotient),
		.remainder_q (remainder),
		.magnitude_q (quotient_magnitude),
		.dbz_q       (m_tuser)
	);

	assign m_tdata = {quotient_magnitude, remainder, quotient};

endmodule

/* sv/sdr_prep.sv */
module sdr_prep (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [sdr_pkg::DataW-1:0]          numerator,
	input  logic [sdr_pkg::DataW-1:0]          denominator,
	output logic                               valid_s1,
	output sdr_pkg::sdr_work_t                 work_s1
);

	logic [sdr_pkg::DataW-1:0] an;
	logic [sdr_pkg::DataW-1:0] ad;

	assign an = numerator[sdr_pkg::DataW-1] ? (~numerator + 1'b1) : numerator;
	assign ad = denominator[sdr_pkg::DataW-1] ? (~denominator + 1'b1) : denominator;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1.rem   <= '0;
			work_s1.quo   <= an;
			work_s1.den   <= ad;
			work_s1.num   <= numerator;
			work_s1.n_neg <= numerator[sdr_pkg::DataW-1];
			work_s1.q_neg <= numerator[sdr_pkg::DataW-1] ^ denominator[sdr_pkg::DataW-1];
			work_s1.dbz   <= (denominator == '0);
		end
	end

endmodule

/* sv/sdr_step.sv */
module sdr_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  sdr_pkg::sdr_work_t in_work,
	output logic               valid_q,
	output sdr_pkg::sdr_work_t work_q
);

	logic [sdr_pkg::DataW:0]   trial;
	logic [sdr_pkg::DataW:0]   diff;
	logic                      take;
	sdr_pkg::sdr_work_t        nxt;

	// one restoring step: shift in next dividend bit, subtract if it fits
	assign trial = {in_work.rem, in_work.quo[sdr_pkg::DataW-1]};
	assign diff  = trial - {1'b0, in_work.den};
	assign take  = ~diff[sdr_pkg::DataW];

	always_comb begin
		nxt     = in_work;
		nxt.rem = take ? diff[sdr_pkg::DataW-1:0] : trial[sdr_pkg::DataW-1:0];
		nxt.quo = {in_work.quo[sdr_pkg::DataW-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= nxt;
		end
	end

endmodule

/* sv/sdr_fix.sv */
module sdr_fix (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  sdr_pkg::sdr_work_t           in_work,
	output logic                         valid_q,
	output logic [sdr_pkg::DataW-1:0]    quotient_q,
	output logic [sdr_pkg::DataW-1:0]    remainder_q,
	output logic [sdr_pkg::DataW-1:0]    magnitude_q,
	output logic                         dbz_q
);

	logic [sdr_pkg::DataW-1:0] q_signed;
	logic [sdr_pkg::DataW-1:0] r_signed;

	assign q_signed = in_work.q_neg ? (~in_work.quo + 1'b1) : in_work.quo;
	assign r_signed = in_work.n_neg ? (~in_work.rem + 1'b1) : in_work.rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quotient_q  <= in_work.dbz ? '0 : q_signed;
			remainder_q <= in_work.dbz ? in_work.num : r_signed;
			magnitude_q <= in_work.dbz ? '0 : in_work.quo;
			dbz_q       <= in_work.dbz;
		end
	end

endmodule
